FILE: rtl/core/psht_pkg.sv
// ============================================================================
// Piece-square history table package
// Shared constants, command codes and helper functions for the history table.
// ============================================================================
`default_nettype none

package psht_pkg;

    // Table geometry.
    localparam int DEF_HISTORY_LIMIT = 16384;
    localparam int PIECE_KINDS       = 12;
    localparam int SQUARES           = 64;
    localparam int TABLE_DEPTH       = PIECE_KINDS * SQUARES;
    localparam int IDX_W             = $clog2(TABLE_DEPTH);
    localparam int SQ_W              = $clog2(SQUARES);

    // Field widths of one item.
    localparam int CMD_W   = 2;
    localparam int PIECE_W = 4;
    localparam int MOVE_W  = 16;
    localparam int ENTRY_W = 16;

    // Stream widths, padded to whole bytes.
    localparam int S_FIELDS_W = PIECE_W + MOVE_W + ENTRY_W + 2 * MOVE_W;
    localparam int S_TDATA_W  = ((S_FIELDS_W + 7) / 8) * 8;
    localparam int M_FIELDS_W = ENTRY_W + 1;
    localparam int M_TDATA_W  = ((M_FIELDS_W + 7) / 8) * 8;

    // Command codes carried in tuser.
    localparam logic [CMD_W-1:0] CMD_UPDATE = 2'd0;
    localparam logic [CMD_W-1:0] CMD_QUERY  = 2'd1;
    localparam logic [CMD_W-1:0] CMD_CLEAR  = 2'd2;

    typedef logic signed [ENTRY_W-1:0] entry_t;

    // Halve a score, rounding toward zero.
    function automatic entry_t halve_entry(input entry_t x);
        entry_t adj;
        adj = x[ENTRY_W-1] ? x + entry_t'(1) : x;
        return adj >>> 1;
    endfunction

endpackage

`default_nettype wire

FILE: rtl/core/psht_scale.sv
// ============================================================================
// Gravity scale unit
// Computes floor(h_mag * b_mag / HISTORY_LIMIT) in two registered multiplies:
// the magnitude product, then a multiply by a fixed reciprocal and a shift.
// ============================================================================
`default_nettype none

module psht_scale #(
    parameter int HISTORY_LIMIT = 16384
) (
    input  wire                                  aclk,
    input  wire [$clog2(HISTORY_LIMIT+1)-1:0]    h_mag,
    input  wire [$clog2(HISTORY_LIMIT+1)-1:0]    b_mag,
    output logic [$clog2(HISTORY_LIMIT+1)-1:0]   q
);

    localparam int MAG_W   = $clog2(HISTORY_LIMIT + 1);
    localparam int PROD_W  = 2 * MAG_W;
    localparam int SHIFT   = PROD_W + $clog2(HISTORY_LIMIT);
    localparam int RECIP_W = PROD_W + 2;
    localparam int FULL_W  = PROD_W + RECIP_W;

    // Rounded-up reciprocal; exact for every product below 2**PROD_W.
    localparam longint unsigned RECIP_FULL =
        ((longint'(1) << SHIFT) + longint'(HISTORY_LIMIT) - 1) / longint'(HISTORY_LIMIT);
    localparam logic [RECIP_W-1:0] RECIP = RECIP_W'(RECIP_FULL);

    logic [PROD_W-1:0] prod_reg;
    logic [FULL_W-1:0] scaled_reg;

    // First stage: magnitude product.
    always_ff @(posedge aclk) begin
        prod_reg <= PROD_W'(h_mag) * PROD_W'(b_mag);
    end

    // Second stage: multiply by the reciprocal.
    always_ff @(posedge aclk) begin
        scaled_reg <= FULL_W'(prod_reg) * FULL_W'(RECIP);
    end

    assign q = scaled_reg[SHIFT +: MAG_W];

endmodule

`default_nettype wire

FILE: rtl/core/piece_square_history_table.sv
// ============================================================================
// Piece-square history table
// Move-ordering score table with gravity updates, killer ranking and aging.
// ============================================================================
// Usage: each item on the s_ channel carries a command in s_tuser (update,
// rank query or clear) and the piece, move, bonus and killer moves in
// s_tdata. Every item produces exactly one result item on the m_ channel:
// the rank or updated score in bits 15:0 and the aged flag in bit 16.
// The scores live in one synchronous memory of 768 entries. A query result
// is loaded through the FETCH and DONE states after the memory read; an
// update result passes SCALE and APPLY in between, for the two registered
// multiplies of the gravity term. An update that pushes a score to the limit
// halves the whole table with a read-modify-write sweep of all 768 entries;
// a clear writes zeros to all 768 entries. One item is in work at a time, so
// the block takes no new item until the result of the last one is loaded.
// After reset the block clears all 768 memory entries with s_tready low.
// The result sits in an output register; while the receiver stalls the
// block still accepts and processes the next item, and waits to load its
// result until the output register has been taken.
// ============================================================================
`default_nettype none

module piece_square_history_table
    import psht_pkg::*;
#(
    parameter int HISTORY_LIMIT = DEF_HISTORY_LIMIT
) (
    input  wire                    aclk,
    input  wire                    aresetn,
    // Input item.
    input  wire                    s_tvalid,
    output logic                   s_tready,
    // moving_piece[3:0], move_code[19:4], bonus[35:20],
    // first_killer[51:36], second_killer[67:52], zero padding above
    input  wire [S_TDATA_W-1:0]    s_tdata,
    // cmd[1:0]
    input  wire [CMD_W-1:0]        s_tuser,
    // Result item.
    output logic                   m_tvalid,
    input  wire                    m_tready,
    // rank[15:0], aged[16], zero padding above
    output logic [M_TDATA_W-1:0]   m_tdata
);

    localparam int MAG_W = $clog2(HISTORY_LIMIT + 1);
    localparam int SUM_W = ENTRY_W + 2;

    localparam entry_t LIMIT_E    = ENTRY_W'(HISTORY_LIMIT);
    localparam entry_t HALF_LIM_E = ENTRY_W'(HISTORY_LIMIT / 2);
    localparam logic signed [SUM_W-1:0] LIMIT_S = SUM_W'(HISTORY_LIMIT);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_DEPTH - 1);

    typedef enum logic [7:0] {
        ST_INIT  = 8'b0000_0001,
        ST_IDLE  = 8'b0000_0010,
        ST_FETCH = 8'b0000_0100,
        ST_SCALE = 8'b0000_1000,
        ST_APPLY = 8'b0001_0000,
        ST_AGE   = 8'b0010_0000,
        ST_CLEAR = 8'b0100_0000,
        ST_DONE  = 8'b1000_0000
    } state_t;

    // Decoded item held while it is in work.
    typedef struct packed {
        logic [CMD_W-1:0] cmd;
        logic             piece_ok;
        logic [IDX_W-1:0] idx;
        entry_t           bonus;
        logic [MAG_W-1:0] mag;
        logic             k1_hit;
        logic             k2_hit;
    } item_t;

    state_t            state_reg, state_next;
    item_t             item_reg, item_next;
    logic [IDX_W-1:0]  sweep_reg, sweep_next;
    logic              wb_valid_reg, wb_valid_next;
    logic [IDX_W-1:0]  wb_addr_reg, wb_addr_next;
    entry_t            h_reg, h_next;
    entry_t            res_rank_reg, res_rank_next;
    logic              res_aged_reg, res_aged_next;
    logic              m_valid_reg, m_valid_next;
    entry_t            m_rank_reg, m_rank_next;
    logic              m_aged_reg, m_aged_next;

    // Score memory.
    entry_t            table_mem [TABLE_DEPTH];
    entry_t            rd_data_reg;
    logic [IDX_W-1:0]  mem_raddr;
    logic              mem_we;
    logic [IDX_W-1:0]  mem_waddr;
    entry_t            mem_wdata;

    // Input field decode.
    logic [PIECE_W-1:0] in_piece;
    logic [MOVE_W-1:0]  in_move, in_k1, in_k2;
    entry_t             in_bonus, in_sat;
    logic               in_piece_ok;
    logic [IDX_W-1:0]   in_idx;
    logic               accept;

    // Gravity arithmetic.
    logic [MAG_W-1:0]         rd_mag;
    logic [MAG_W-1:0]         scale_q;
    logic signed [SUM_W-1:0]  grav, new_sum;
    entry_t                   new_entry;
    logic                     hit_limit;
    logic                     out_free;

    assign in_piece = s_tdata[PIECE_W-1:0];
    assign in_move  = s_tdata[PIECE_W +: MOVE_W];
    assign in_bonus = entry_t'(s_tdata[PIECE_W+MOVE_W +: ENTRY_W]);
    assign in_k1    = s_tdata[PIECE_W+MOVE_W+ENTRY_W +: MOVE_W];
    assign in_k2    = s_tdata[PIECE_W+2*MOVE_W+ENTRY_W +: MOVE_W];

    assign in_piece_ok = in_piece < PIECE_W'(PIECE_KINDS);
    assign in_idx      = in_piece_ok ? IDX_W'({in_piece, in_move[SQ_W-1:0]}) : '0;

    // Bonus saturation to the limit.
    always_comb begin
        if (in_bonus > LIMIT_E) begin
            in_sat = LIMIT_E;
        end else if (in_bonus < -LIMIT_E) begin
            in_sat = -LIMIT_E;
        end else begin
            in_sat = in_bonus;
        end
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign out_free = !m_valid_reg || m_tready;

    // Memory read address follows the phase of the work.
    always_comb begin
        case (state_reg)
            ST_IDLE: mem_raddr = in_idx;
            ST_AGE:  mem_raddr = sweep_reg;
            default: mem_raddr = item_reg.idx;
        endcase
    end

    // Memory write port: halving write-back, update write, or zero sweep.
    always_comb begin
        mem_we    = 1'b0;
        mem_waddr = item_reg.idx;
        mem_wdata = new_entry;
        if (wb_valid_reg) begin
            mem_we    = 1'b1;
            mem_waddr = wb_addr_reg;
            mem_wdata = halve_entry(rd_data_reg);
        end else if (state_reg == ST_APPLY) begin
            mem_we = 1'b1;
        end else if (state_reg == ST_INIT || state_reg == ST_CLEAR) begin
            mem_we    = 1'b1;
            mem_waddr = sweep_reg;
            mem_wdata = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            table_mem[mem_waddr] <= mem_wdata;
        end
        rd_data_reg <= table_mem[mem_raddr];
    end

    // Gravity term: floor(|h| * |bonus| / limit), signed like h.
    assign rd_mag = rd_data_reg[ENTRY_W-1] ? MAG_W'(-rd_data_reg) : MAG_W'(rd_data_reg);

    psht_scale #(
        .HISTORY_LIMIT (HISTORY_LIMIT)
    ) u_scale (
        .aclk  (aclk),
        .h_mag (rd_mag),
        .b_mag (item_reg.mag),
        .q     (scale_q)
    );

    assign grav      = h_reg[ENTRY_W-1] ? -SUM_W'(scale_q) : SUM_W'(scale_q);
    assign new_sum   = SUM_W'(h_reg) + SUM_W'(item_reg.bonus) - grav;
    assign new_entry = ENTRY_W'(new_sum);
    assign hit_limit = (new_sum >= LIMIT_S) || (new_sum <= -LIMIT_S);

    // Sequencer.
    always_comb begin
        state_next    = state_reg;
        item_next     = item_reg;
        sweep_next    = sweep_reg;
        wb_valid_next = 1'b0;
        wb_addr_next  = wb_addr_reg;
        h_next        = h_reg;
        res_rank_next = res_rank_reg;
        res_aged_next = res_aged_reg;
        m_valid_next  = m_valid_reg && !m_tready;
        m_rank_next   = m_rank_reg;
        m_aged_next   = m_aged_reg;

        case (state_reg)
            ST_INIT: begin
                sweep_next = sweep_reg + IDX_W'(1);
                if (sweep_reg == LAST_IDX) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (accept) begin
                    item_next.cmd      = s_tuser;
                    item_next.piece_ok = in_piece_ok;
                    item_next.idx      = in_idx;
                    item_next.bonus    = in_sat;
                    item_next.mag      = in_sat[ENTRY_W-1] ? MAG_W'(-in_sat) : MAG_W'(in_sat);
                    item_next.k1_hit   = (in_move == in_k1);
                    item_next.k2_hit   = (in_move == in_k2);
                    state_next         = ST_FETCH;
                end
            end
            ST_FETCH: begin
                h_next        = rd_data_reg;
                res_rank_next = '0;
                res_aged_next = 1'b0;
                state_next    = ST_DONE;
                case (item_reg.cmd)
                    CMD_UPDATE: begin
                        if (item_reg.piece_ok) begin
                            state_next = ST_SCALE;
                        end
                    end
                    CMD_QUERY: begin
                        if (item_reg.k1_hit) begin
                            res_rank_next = LIMIT_E + entry_t'(2);
                        end else if (item_reg.k2_hit) begin
                            res_rank_next = LIMIT_E + entry_t'(1);
                        end else if (item_reg.piece_ok) begin
                            res_rank_next = rd_data_reg;
                        end
                    end
                    CMD_CLEAR: begin
                        sweep_next = '0;
                        state_next = ST_CLEAR;
                    end
                    default: begin
                        state_next = ST_DONE;
                    end
                endcase
            end
            ST_SCALE: begin
                state_next = ST_APPLY;
            end
            ST_APPLY: begin
                // The new score is written here; reaching the limit starts aging.
                if (hit_limit) begin
                    res_rank_next = halve_entry(new_entry);
                    res_aged_next = 1'b1;
                    sweep_next    = '0;
                    state_next    = ST_AGE;
                end else begin
                    res_rank_next = new_entry;
                    state_next    = ST_DONE;
                end
            end
            ST_AGE: begin
                // Read one entry per cycle, write it back halved in the cycle after.
                wb_valid_next = 1'b1;
                wb_addr_next  = sweep_reg;
                sweep_next    = sweep_reg + IDX_W'(1);
                if (sweep_reg == LAST_IDX) begin
                    state_next = ST_DONE;
                end
            end
            ST_CLEAR: begin
                sweep_next = sweep_reg + IDX_W'(1);
                if (sweep_reg == LAST_IDX) begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    m_rank_next  = res_rank_reg;
                    m_aged_next  = res_aged_reg;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_INIT;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_INIT;
            sweep_reg    <= '0;
            wb_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            state_reg    <= state_next;
            sweep_reg    <= sweep_next;
            wb_valid_reg <= wb_valid_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge aclk) begin
        item_reg     <= item_next;
        wb_addr_reg  <= wb_addr_next;
        h_reg        <= h_next;
        res_rank_reg <= res_rank_next;
        res_aged_reg <= res_aged_next;
        m_rank_reg   <= m_rank_next;
        m_aged_reg   <= m_aged_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = M_TDATA_W'({m_aged_reg, m_rank_reg});

    // Only one item is in work: an accepted item closes the input at once.
    assert property (@(posedge aclk) disable iff (!aresetn)
        accept |=> !s_tready)
        else $error("input accepted while an item is in work");

    // Nothing writes the table while the block waits for an item.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_IDLE) |-> !mem_we)
        else $error("table write while idle");

    // A result appears only after the sequencer has finished an item.
    assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) |-> $past(state_reg == ST_DONE))
        else $error("result loaded outside the done phase");

    // After aging the reported score lies within half the limit.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && m_aged_reg) |-> (m_rank_reg <= HALF_LIM_E && m_rank_reg >= -HALF_LIM_E))
        else $error("aged score outside half the limit");

endmodule

`default_nettype wire

FILE: verif/tb_top.sv
`timescale 1ns / 100ps
// ============================================================================
// Piece-square history table regression
// Drives update, rank query and clear items into the history table and checks
// every result item against a shadow copy of the score table that applies the
// same gravity update, killer ranking, table aging and clearing.
// ============================================================================

module tb_top;
    import psht_pkg::*;

    localparam int LIMIT         = DEF_HISTORY_LIMIT;
    localparam int RANDOM_ITEMS  = 1150;
    localparam int REPORT_LIMIT  = 10;
    localparam int SETTLE_CYCLES = 800;

    // The one command code the block does not define.
    localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

    typedef struct packed {
        logic [ENTRY_W-1:0] rank;
        logic               aged;
    } rank_item_t;

    // Shadow score table plus the queue of ranks still owed by the block.
    class history_scoreboard;
        int         shadow_scores [TABLE_DEPTH];
        rank_item_t pending_ranks [$];
        int         mismatches;
        int         results_seen;
        int         updates;
        int         agings;
        int         queries;
        int         killer_hits;
        int         clears;
        int         unused_cmds;

        function void clear_scores();
            foreach (shadow_scores[i]) shadow_scores[i] = 0;
        endfunction

        function new();
            clear_scores();
        endfunction

        // Work out the result of one accepted item and update the shadow table.
        function void note_item(input logic [CMD_W-1:0] cmd,
                                input logic [PIECE_W-1:0] piece,
                                input logic [MOVE_W-1:0] move,
                                input logic signed [ENTRY_W-1:0] bonus,
                                input logic [MOVE_W-1:0] killer_a,
                                input logic [MOVE_W-1:0] killer_b);
            int         idx;
            int         b;
            int         mag;
            int         h;
            int         nh;
            rank_item_t res;
            res = '0;
            idx = int'(piece) * SQUARES + int'(move[SQ_W-1:0]);
            case (cmd)
                CMD_UPDATE: begin
                    updates++;
                    if (piece < PIECE_KINDS) begin
                        b = int'(bonus);
                        if (b > LIMIT) b = LIMIT;
                        else if (b < -LIMIT) b = -LIMIT;
                        mag = (b < 0) ? -b : b;
                        h = shadow_scores[idx];
                        // Gravity: pull the entry toward the bonus.
                        nh = h + b - (h * mag) / LIMIT;
                        shadow_scores[idx] = nh;
                        // Reaching the limit halves the whole table.
                        if (nh >= LIMIT || nh <= -LIMIT) begin
                            foreach (shadow_scores[i]) shadow_scores[i] = shadow_scores[i] / 2;
                            res.aged = 1'b1;
                            agings++;
                        end
                        res.rank = ENTRY_W'(shadow_scores[idx]);
                    end
                end
                CMD_QUERY: begin
                    queries++;
                    if (move == killer_a) begin
                        res.rank = ENTRY_W'(LIMIT + 2);
                        killer_hits++;
                    end else if (move == killer_b) begin
                        res.rank = ENTRY_W'(LIMIT + 1);
                        killer_hits++;
                    end else if (piece < PIECE_KINDS) begin
                        res.rank = ENTRY_W'(shadow_scores[idx]);
                    end
                end
                CMD_CLEAR: begin
                    clears++;
                    clear_scores();
                end
                default: begin
                    unused_cmds++;
                end
            endcase
            pending_ranks.push_back(res);
        endfunction

        // Compare one result item with the oldest rank still owed.
        function void check_result(input logic [M_TDATA_W-1:0] data);
            rank_item_t want;
            results_seen++;
            if (pending_ranks.size() == 0) begin
                mismatches++;
                if (mismatches <= REPORT_LIMIT)
                    $display("%0t: result %0d with nothing expected: rank %0d aged %0b",
                             $realtime, results_seen, $signed(data[ENTRY_W-1:0]),
                             data[ENTRY_W]);
                return;
            end
            want = pending_ranks.pop_front();
            if (data[ENTRY_W-1:0] !== want.rank || data[ENTRY_W] !== want.aged) begin
                mismatches++;
                if (mismatches <= REPORT_LIMIT)
                    $display("%0t: result %0d: expected rank %0d aged %0b, got rank %0d aged %0b",
                             $realtime, results_seen, $signed(want.rank), want.aged,
                             $signed(data[ENTRY_W-1:0]), data[ENTRY_W]);
            end
        endfunction
    endclass

    logic                 aclk;
    logic                 aresetn;
    logic                 s_tvalid;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata;
    logic [CMD_W-1:0]     s_tuser;
    logic                 m_tvalid;
    logic                 m_tready;
    logic [M_TDATA_W-1:0] m_tdata;

    int send_idle_pct  = 0;
    int recv_stall_pct = 0;

    history_scoreboard scores = new();

    piece_square_history_table u_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    // Free-running clock.
    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // Hang guard: far beyond the slowest legal run.
    initial begin
        #50_000_000;
        $display("piece_square_history_table regression: fail");
        $finish;
    end

    // Receiver readiness changes on the falling edge.
    always @(negedge aclk) begin
        m_tready = ($urandom_range(99) >= recv_stall_pct);
    end

    // Result items are taken at the rising edge.
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready)
            scores.check_result(m_tdata);
    end

    // Present one item, hold it until accepted, then return at a falling edge.
    task automatic send_item(input logic [CMD_W-1:0] cmd,
                             input logic [PIECE_W-1:0] piece,
                             input logic [MOVE_W-1:0] move,
                             input logic signed [ENTRY_W-1:0] bonus,
                             input logic [MOVE_W-1:0] killer_a,
                             input logic [MOVE_W-1:0] killer_b);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid = 1'b0;
            @(negedge aclk);
        end
        s_tvalid = 1'b1;
        s_tuser  = cmd;
        s_tdata  = S_TDATA_W'({killer_b, killer_a, bonus, move, piece});
        do @(posedge aclk); while (!s_tready);
        scores.note_item(cmd, piece, move, bonus, killer_a, killer_b);
        @(negedge aclk);
    endtask

    // Stop sending and wait until every owed result has come back.
    task automatic drain();
        s_tvalid = 1'b0;
        while (scores.pending_ranks.size() != 0) @(negedge aclk);
    endtask

    // One random item, biased toward a few hot entries so history builds up.
    task automatic random_item();
        logic [CMD_W-1:0]          cmd;
        logic [PIECE_W-1:0]        piece;
        logic [MOVE_W-1:0]         move;
        logic [MOVE_W-1:0]         killer_a;
        logic [MOVE_W-1:0]         killer_b;
        logic signed [ENTRY_W-1:0] bonus;
        int                        pick;
        pick = $urandom_range(99);
        if (pick < 55)      cmd = CMD_UPDATE;
        else if (pick < 96) cmd = CMD_QUERY;
        else if (pick < 97) cmd = CMD_CLEAR;
        else                cmd = CMD_UNUSED;

        if ($urandom_range(99) < 6)       piece = PIECE_W'($urandom_range(15, PIECE_KINDS));
        else if ($urandom_range(99) < 70) piece = PIECE_W'($urandom_range(3));
        else                              piece = PIECE_W'($urandom_range(PIECE_KINDS - 1));

        move = MOVE_W'($urandom());
        if ($urandom_range(99) < 70) move[SQ_W-1:0] = SQ_W'($urandom_range(7));

        // Mostly moderate bonuses, some at the limit and some out of range.
        pick = $urandom_range(99);
        if (pick < 3)       bonus = ENTRY_W'($urandom());
        else if (pick < 6)  bonus = ENTRY_W'($urandom_range(1) ? LIMIT : -LIMIT);
        else if (pick < 20) bonus = ENTRY_W'(int'($urandom_range(2 * LIMIT)) - LIMIT);
        else                bonus = ENTRY_W'(int'($urandom_range(4000)) - 2000);

        killer_a = MOVE_W'($urandom());
        killer_b = MOVE_W'($urandom());
        if ($urandom_range(99) < 25) killer_a = move;
        if ($urandom_range(99) < 15) killer_b = move;

        send_item(cmd, piece, move, bonus, killer_a, killer_b);
    endtask

    // Reset, directed items, three random phases, then the verdict.
    initial begin
        s_tvalid = 1'b0;
        s_tdata  = '0;
        s_tuser  = CMD_UPDATE;
        aresetn  = 1'b0;
        repeat (8) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // Directed: empty table, gravity, aging from both signs, saturation,
        // bad piece kinds, killer priority, unused command and clear.
        send_item(CMD_QUERY,  4'd0,  16'h0000, 16'sd0,     16'hFFFF, 16'hFFFE);
        send_item(CMD_UPDATE, 4'd0,  16'h0000, 16'sd100,   16'h0000, 16'h0000);
        send_item(CMD_UPDATE, 4'd0,  16'h0000, -16'sd100,  16'h0000, 16'h0000);
        send_item(CMD_UPDATE, 4'd0,  16'h0000, 16'sd5000,  16'h0000, 16'h0000);
        send_item(CMD_UPDATE, 4'd0,  16'h0000, 16'sd5000,  16'h0000, 16'h0000);
        send_item(CMD_UPDATE, 4'd11, 16'hFFFF, -16'sd16384, 16'h0000, 16'h0000);
        send_item(CMD_UPDATE, 4'd5,  16'h0FC0, 16'sh7FFF,  16'h0000, 16'h0000);
        send_item(CMD_UPDATE, 4'd6,  16'h8001, 16'sh8000,  16'hFFFF, 16'hFFFF);
        send_item(CMD_UPDATE, 4'd12, 16'h0005, 16'sd1000,  16'h0000, 16'h0000);
        send_item(CMD_UPDATE, 4'd15, 16'hFFFF, -16'sd1,    16'h0000, 16'h0000);
        send_item(CMD_QUERY,  4'd11, 16'hFFFF, 16'sd0,     16'h0000, 16'h1234);
        send_item(CMD_QUERY,  4'd3,  16'hABCD, 16'sd0,     16'hABCD, 16'h0000);
        send_item(CMD_QUERY,  4'd3,  16'hABCD, 16'sd0,     16'h0000, 16'hABCD);
        send_item(CMD_QUERY,  4'd3,  16'hFFFF, 16'sd0,     16'hFFFF, 16'hFFFF);
        send_item(CMD_QUERY,  4'd15, 16'h1111, 16'sd0,     16'h0000, 16'h0000);
        send_item(CMD_QUERY,  4'd14, 16'h2222, 16'sd0,     16'h0001, 16'h2222);
        send_item(CMD_QUERY,  4'd0,  16'h0000, 16'sd0,     16'h0001, 16'h0002);
        send_item(CMD_UNUSED, 4'd2,  16'h0000, 16'sh7FFF,  16'h0000, 16'h0000);
        send_item(CMD_UPDATE, 4'd0,  16'h0000, 16'sd0,     16'h0000, 16'h0000);
        send_item(CMD_CLEAR,  4'd0,  16'h0000, 16'sd0,     16'h0000, 16'h0000);
        send_item(CMD_QUERY,  4'd0,  16'h0000, 16'sd0,     16'h0001, 16'h0001);
        send_item(CMD_UPDATE, 4'd2,  16'h0040, 16'sd16384, 16'h0000, 16'h0000);
        send_item(CMD_QUERY,  4'd0,  16'h0000, 16'sd0,     16'h0001, 16'h0001);
        drain();

        // Random phases: slow receiver, then slow sender, then full speed.
        for (int phase = 0; phase < 3; phase++) begin
            send_idle_pct  = (phase == 0) ? 9 : (phase == 1) ? 85 : 0;
            recv_stall_pct = (phase == 0) ? 85 : (phase == 1) ? 9 : 0;
            repeat (RANDOM_ITEMS / 3) random_item();
            drain();
        end

        // Give a stray late result the chance to show up.
        repeat (SETTLE_CYCLES) @(negedge aclk);

        $display("Covered %0d updates with %0d table agings, %0d queries with %0d killer ranks,",
                 scores.updates, scores.agings, scores.queries, scores.killer_hits);
        $display("%0d clears and %0d unused commands; %0d results checked, %0d mismatches.",
                 scores.clears, scores.unused_cmds, scores.results_seen, scores.mismatches);
        if (scores.mismatches == 0 && scores.pending_ranks.size() == 0) begin
            $display("piece_square_history_table regression: pass");
        end else begin
            $display("piece_square_history_table regression: fail");
        end
        $finish;
    end

endmodule
